FILE: design/ising_pkg.sv
// Shared constants, types and codes for the Ising site update unit.
package ising_pkg;

   localparam int SIDE         = 64;
   localparam int SITES        = SIDE * SIDE;
   localparam int SIDE_W       = $clog2(SIDE);
   localparam int SITE_W       = 12;
   localparam int RND_W        = 16;
   localparam int PROB_W       = 16;
   localparam int STEP_W       = 5;
   localparam int MAG_W        = 15;
   localparam int EN_W         = 16;
   localparam int MAG_LIMIT    = 8192;
   localparam int ENERGY_LIMIT = 16384;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 16;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_ADDR_W-1:0] CSR_ACCEPT_FOUR  = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_ACCEPT_EIGHT = CSR_ADDR_W'(1);

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_TRIAL = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC
   } back_state_type;

   typedef struct packed {
      cmd_type           cmd;
      logic              in_range;
      logic [SIDE_W-1:0] row;
      logic [SIDE_W-1:0] row_up;
      logic [SIDE_W-1:0] row_down;
      logic [SIDE_W-1:0] col;
      logic [SIDE_W-1:0] col_left;
      logic [SIDE_W-1:0] col_right;
      logic              spin_value;
      logic [RND_W-1:0]  rnd;
   } task_type;

   typedef struct packed {
      logic queue_full;
      logic clearing;
   } front_gate_type;

endpackage

FILE: design/ising_if.sv
// Channel interfaces: trial requests, results and register writes.
interface ising_req_if;
   import ising_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          cmd;
   logic [SITE_W-1:0]   site;
   logic                spin_value;
   logic [RND_W-1:0]    random_fraction;

   modport source (output valid, cmd, site, spin_value, random_fraction, input ready);
   modport sink   (input valid, cmd, site, spin_value, random_fraction, output ready);
endinterface

interface ising_rsp_if;
   import ising_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     accepted;
   logic                     spin_after;
   logic signed [STEP_W-1:0] energy_step;
   logic signed [MAG_W-1:0]  mag_total;
   logic signed [EN_W-1:0]   energy_total;

   modport source (output valid, accepted, spin_after, energy_step, mag_total, energy_total,
                   input ready);
   modport sink   (input valid, accepted, spin_after, energy_step, mag_total, energy_total,
                   output ready);
endinterface

interface ising_csr_if;
   import ising_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

FILE: design/ising_front.sv
// Front end: accepts request beats and decodes site into row, column and neighbors.
module ising_front
   import ising_pkg::*;
(
   ising_req_if.sink      req_ch,
   input  front_gate_type gate,
   output logic           push,
   output task_type       push_task
);

   logic [SIDE_W-1:0] row;
   logic [SIDE_W-1:0] col;

   always_comb begin
      req_ch.ready = !gate.queue_full && !gate.clearing;
      push         = req_ch.valid && req_ch.ready;

      row = SIDE_W'(req_ch.site / SIDE);
      col = SIDE_W'(req_ch.site % SIDE);

      push_task.cmd        = cmd_type'(req_ch.cmd);
      push_task.in_range   = 32'(req_ch.site) < SITES;
      push_task.row        = row;
      push_task.col        = col;
      push_task.row_up     = (row == '0) ? SIDE_W'(SIDE - 1) : row - 1'b1;
      push_task.row_down   = (row == SIDE_W'(SIDE - 1)) ? '0 : row + 1'b1;
      push_task.col_left   = (col == '0) ? SIDE_W'(SIDE - 1) : col - 1'b1;
      push_task.col_right  = (col == SIDE_W'(SIDE - 1)) ? '0 : col + 1'b1;
      push_task.spin_value = req_ch.spin_value;
      push_task.rnd        = req_ch.random_fraction;
   end

endmodule

FILE: design/ising_queue.sv
// Short FIFO of decoded tasks between front end and back end.
module ising_queue
   import ising_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  task_type push_task,
   input  logic     pop,
   output task_type head,
   output logic     full,
   output logic     empty
);

   task_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_task;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

endmodule

FILE: design/ising_back.sv
// Back end: spin row memories, acceptance test, totals, registers and result stage.
module ising_back
   import ising_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   ising_csr_if.sink    csr_ch,
   ising_rsp_if.source  rsp_ch,
   input  task_type     head,
   input  logic         q_empty,
   output logic         pop,
   output logic         clearing
);

   localparam logic signed [MAG_W:0] MAG_HI = (MAG_W + 1)'(MAG_LIMIT);
   localparam logic signed [MAG_W:0] MAG_LO = (MAG_W + 1)'(-MAG_LIMIT);
   localparam logic signed [MAG_W:0] MAG_TWO = (MAG_W + 1)'(2);
   localparam logic signed [EN_W:0]  EN_HI = (EN_W + 1)'(ENERGY_LIMIT);
   localparam logic signed [EN_W:0]  EN_LO = (EN_W + 1)'(-ENERGY_LIMIT);

   // two copies of the row store: copy a serves the rows above and below, copy b the own row
   logic [SIDE-1:0] spin_bank_a [SIDE];
   logic [SIDE-1:0] spin_bank_b [SIDE];

   back_state_type           state_ff, state_in;
   logic [SIDE_W-1:0]        clr_row_ff, clr_row_in;
   task_type                 task_ff;
   logic [SIDE-1:0]          up_row_ff, down_row_ff, cur_row_ff;
   logic [PROB_W-1:0]        prob_four_ff, prob_eight_ff;
   logic signed [MAG_W-1:0]  mag_sum_ff, mag_sum_in;
   logic signed [EN_W-1:0]   energy_sum_ff, energy_sum_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     accepted_ff;
   logic                     spin_after_ff;
   logic signed [STEP_W-1:0] step_ff;

   logic                     commit;
   logic                     mem_we;
   logic [SIDE_W-1:0]        mem_waddr;
   logic [SIDE-1:0]          mem_wdata;

   logic                     spin_cur;
   logic [2:0]               agree;
   logic [STEP_W-1:0]        de;
   logic                     flip;
   logic                     is_load;
   logic                     is_trial;
   logic                     accepted;
   logic [SIDE-1:0]          new_row;
   logic                     spin_after;
   logic signed [STEP_W-1:0] step;
   logic signed [MAG_W:0]    mag_wide;
   logic signed [EN_W:0]     en_wide;

   // evaluation of the task whose rows were read into the row registers when it was popped
   always_comb begin
      spin_cur = cur_row_ff[task_ff.col];
      agree = {2'b00, up_row_ff[task_ff.col] == spin_cur}
            + {2'b00, down_row_ff[task_ff.col] == spin_cur}
            + {2'b00, cur_row_ff[task_ff.col_left] == spin_cur}
            + {2'b00, cur_row_ff[task_ff.col_right] == spin_cur};
      de = {agree, 2'b00} - STEP_W'(8);

      priority if (agree <= 3'd2) begin
         flip = 1'b1;
      end else if (agree == 3'd3) begin
         flip = task_ff.rnd < prob_four_ff;
      end else if (agree == 3'd4) begin
         flip = task_ff.rnd < prob_eight_ff;
      end else begin
         flip = 1'b0;
      end

      is_load  = (task_ff.cmd == CMD_LOAD);
      is_trial = (task_ff.cmd == CMD_TRIAL);
      accepted = task_ff.in_range && is_trial && flip;

      new_row = cur_row_ff;
      if (task_ff.in_range && is_load) begin
         new_row[task_ff.col] = task_ff.spin_value;
      end else if (accepted) begin
         new_row[task_ff.col] = ~spin_cur;
      end
      spin_after = task_ff.in_range && new_row[task_ff.col];
      step       = accepted ? $signed(de) : '0;

      mag_wide = $signed({mag_sum_ff[MAG_W-1], mag_sum_ff}) + (spin_cur ? -MAG_TWO : MAG_TWO);
      en_wide  = $signed({energy_sum_ff[EN_W-1], energy_sum_ff})
               + $signed({{(EN_W + 1 - STEP_W){de[STEP_W-1]}}, de});
   end

   // sequencer: clear pass, then read rows / execute per task
   always_comb begin
      state_in   = state_ff;
      clr_row_in = clr_row_ff;
      pop        = 1'b0;
      commit     = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = clr_row_ff;
      mem_wdata  = '1;
      unique case (state_ff)
         BK_CLEAR: begin
            mem_we = 1'b1;
            if (clr_row_ff == SIDE_W'(SIDE - 1)) begin
               state_in = BK_IDLE;
            end else begin
               clr_row_in = clr_row_ff + 1'b1;
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               commit    = 1'b1;
               mem_we    = task_ff.in_range && (is_load || accepted);
               mem_waddr = task_ff.row;
               mem_wdata = new_row;
               state_in  = BK_IDLE;
            end
         end
         default: state_in = BK_CLEAR;
      endcase
   end

   always_comb begin
      mag_sum_in    = mag_sum_ff;
      energy_sum_in = energy_sum_ff;
      if (commit) begin
         if (task_ff.cmd == CMD_CLEAR) begin
            mag_sum_in    = '0;
            energy_sum_in = '0;
         end else if (accepted) begin
            if (mag_wide > MAG_HI) begin
               mag_sum_in = MAG_W'(MAG_HI);
            end else if (mag_wide < MAG_LO) begin
               mag_sum_in = MAG_W'(MAG_LO);
            end else begin
               mag_sum_in = MAG_W'(mag_wide);
            end
            if (en_wide > EN_HI) begin
               energy_sum_in = EN_W'(EN_HI);
            end else if (en_wide < EN_LO) begin
               energy_sum_in = EN_W'(EN_LO);
            end else begin
               energy_sum_in = EN_W'(en_wide);
            end
         end
      end
      rsp_valid_in = commit || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_CLEAR;
         clr_row_ff    <= '0;
         mag_sum_ff    <= '0;
         energy_sum_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         prob_four_ff  <= '0;
         prob_eight_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clr_row_ff    <= clr_row_in;
         mag_sum_ff    <= mag_sum_in;
         energy_sum_ff <= energy_sum_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_ch.valid) begin
            if (csr_ch.addr == CSR_ACCEPT_FOUR) begin
               prob_four_ff <= PROB_W'(csr_ch.wdata);
            end else if (csr_ch.addr == CSR_ACCEPT_EIGHT) begin
               prob_eight_ff <= PROB_W'(csr_ch.wdata);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         spin_bank_a[mem_waddr] <= mem_wdata;
         spin_bank_b[mem_waddr] <= mem_wdata;
      end
      if (pop) begin
         task_ff     <= head;
         up_row_ff   <= spin_bank_a[head.row_up];
         down_row_ff <= spin_bank_a[head.row_down];
         cur_row_ff  <= spin_bank_b[head.row];
      end
      if (commit) begin
         accepted_ff   <= accepted;
         spin_after_ff <= spin_after;
         step_ff       <= step;
      end
   end

   assign csr_ch.ready        = 1'b1;
   assign clearing            = (state_ff == BK_CLEAR);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.accepted     = accepted_ff;
   assign rsp_ch.spin_after   = spin_after_ff;
   assign rsp_ch.energy_step  = step_ff;
   assign rsp_ch.mag_total    = mag_sum_ff;
   assign rsp_ch.energy_total = energy_sum_ff;

endmodule

FILE: design/ising_metropolis_site_update_unit.sv
// Top level of the Ising Metropolis site update unit.
//
// req_ch carries one command per beat: load a spin, run a Metropolis trial at a
// site, clear the magnetization and energy totals, or do nothing. rsp_ch returns
// exactly one result beat per request, in order. csr_ch writes the two acceptance
// thresholds (index 0 for an energy change of 4, index 1 for 8); it is always
// ready. The user must write it only while the unit is idle; the unit does not
// enforce this. Spins live in a row-wide memory, duplicated so that the rows
// above, below and at the site are read in the same cycle. In the back end each
// item's rows are read, then it is evaluated and its row written back once the
// result register is free; a new item is taken only after that write-back.
// A two-entry queue sits between request decode and the back end, and a result
// register holds a finished beat, so requests keep flowing while rsp_ch stalls
// until the queue fills. After reset the row memory is set to all spins up, one
// row at a time over all SIDE (64) rows, during which req_ch is not ready;
// totals and thresholds reset to zero.
module ising_metropolis_site_update_unit
   import ising_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   ising_req_if.sink    req_ch,
   ising_rsp_if.source  rsp_ch,
   ising_csr_if.sink    csr_ch
);

   front_gate_type gate;
   logic           push;
   task_type       push_task;
   logic           pop;
   task_type       head;
   logic           q_full;
   logic           q_empty;
   logic           clearing;

   assign gate.queue_full = q_full;
   assign gate.clearing   = clearing;

   ising_front u_front (
      .req_ch    (req_ch),
      .gate      (gate),
      .push      (push),
      .push_task (push_task)
   );

   ising_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_task (push_task),
      .pop       (pop),
      .head      (head),
      .full      (q_full),
      .empty     (q_empty)
   );

   ising_back u_back (
      .clock    (clock),
      .reset    (reset),
      .csr_ch   (csr_ch),
      .rsp_ch   (rsp_ch),
      .head     (head),
      .q_empty  (q_empty),
      .pop      (pop),
      .clearing (clearing)
   );

endmodule

FILE: design/ising_checker.sv
// Port-level assertions for the Ising site update unit, bound to the top level.
module ising_checker
   import ising_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     rsp_accepted,
   input logic                     rsp_spin_after,
   input logic signed [STEP_W-1:0] rsp_energy_step,
   input logic signed [MAG_W-1:0]  rsp_mag_total,
   input logic signed [EN_W-1:0]   rsp_energy_total
);

   localparam logic signed [MAG_W-1:0] MAG_HI = MAG_W'(MAG_LIMIT);
   localparam logic signed [MAG_W-1:0] MAG_LO = MAG_W'(-MAG_LIMIT);
   localparam logic signed [EN_W-1:0]  EN_HI  = EN_W'(ENERGY_LIMIT);
   localparam logic signed [EN_W-1:0]  EN_LO  = EN_W'(-ENERGY_LIMIT);

   // memory init pass follows reset: no request taken, no result shown
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("unit active right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({rsp_accepted, rsp_spin_after, rsp_energy_step,
                     rsp_mag_total, rsp_energy_total}))
      else $error("stalled result beat changed");

   a_reject_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_energy_step == '0)
      else $error("energy step on a rejected item");

   a_totals_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mag_total <= MAG_HI && rsp_mag_total >= MAG_LO
         && rsp_energy_total <= EN_HI && rsp_energy_total >= EN_LO)
      else $error("running total beyond saturation limit");

endmodule

bind ising_metropolis_site_update_unit ising_checker u_ising_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_accepted     (rsp_ch.accepted),
   .rsp_spin_after   (rsp_ch.spin_after),
   .rsp_energy_step  (rsp_ch.energy_step),
   .rsp_mag_total    (rsp_ch.mag_total),
   .rsp_energy_total (rsp_ch.energy_total)
);

FILE: sim/ising_metropolis_site_update_unit_tb.sv
// Self-checking testbench for the Ising Metropolis site update unit.
module ising_metropolis_site_update_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ising_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 4;
   localparam int RANDOM_ITEMS = 1300;
   localparam int PHASES       = 6;
   localparam int SAT_PAIRS    = 100;
   localparam int SAT_SITE     = (SIDE / 2) * SIDE + SIDE / 2;
   localparam int HOLD_AT      = 600;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 2000;
   localparam int IDLE_GAP     = 4;
   localparam int DRAIN_CYCLES = 16;
   localparam int GAP_PCT      = 7;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic                     accepted;
      logic                     spin_after;
      logic signed [STEP_W-1:0] energy_step;
      logic signed [MAG_W-1:0]  mag_total;
      logic signed [EN_W-1:0]   energy_total;
   } site_result_type;

   typedef struct {
      logic                  is_csr;
      logic [CSR_ADDR_W-1:0] reg_idx;
      cmd_type               cmd;
      logic [SITE_W-1:0]     site;
      logic                  spin_value;
      logic [RND_W-1:0]      value;   // random fraction, or write data on a register row
      logic                  typed;
      site_result_type       want;
   } plan_row_type;

   logic clock;
   logic reset;
   bit   no_gaps;
   int   mismatch_count;
   int   results_seen;
   int   stall_count;
   int   beats_sent;
   int   trials_sent;
   int   flips_seen;
   int   clamp_hits;
   int   reg_writes;

   // predictor state
   logic [SITES-1:0]  lattice;
   int                mag_sum;
   int                energy_sum;
   logic [PROB_W-1:0] thr_four;
   logic [PROB_W-1:0] thr_eight;

   site_result_type site_results_due[$];
   plan_row_type    plan[$];

   ising_req_if req_ch ();
   ising_rsp_if rsp_ch ();
   ising_csr_if csr_ch ();

   ising_metropolis_site_update_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   function automatic int spin_pm(int idx);
      return lattice[idx] ? 1 : -1;
   endfunction

   function automatic int saturate(int v, int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic site_result_type metropolis_update(cmd_type cmd,
         logic [SITE_W-1:0] site, logic spin_value, logic [RND_W-1:0] rnd);
      site_result_type r;
      int row;
      int col;
      int nsum;
      int de;
      logic flip;
      r = '0;
      if (cmd == CMD_CLEAR) begin
         mag_sum = 0;
         energy_sum = 0;
      end
      if (int'(site) < SITES) begin
         case (cmd)
            CMD_LOAD: begin
               lattice[site] = spin_value;
            end
            CMD_TRIAL: begin
               row  = int'(site) / SIDE;
               col  = int'(site) % SIDE;
               nsum = spin_pm(((row + SIDE - 1) % SIDE) * SIDE + col)
                    + spin_pm(((row + 1) % SIDE) * SIDE + col)
                    + spin_pm(row * SIDE + (col + SIDE - 1) % SIDE)
                    + spin_pm(row * SIDE + (col + 1) % SIDE);
               de = 2 * nsum * spin_pm(int'(site));
               if (de <= 0) flip = 1'b1;
               else if (de == 4) flip = rnd < thr_four;
               else if (de == 8) flip = rnd < thr_eight;
               else flip = 1'b0;
               if (flip) begin
                  lattice[site] = ~lattice[site];
                  r.accepted    = 1'b1;
                  r.energy_step = STEP_W'(de);
                  mag_sum    = saturate(mag_sum + 2 * spin_pm(int'(site)), MAG_LIMIT);
                  energy_sum = saturate(energy_sum + de, ENERGY_LIMIT);
               end
            end
            default: ;
         endcase
         r.spin_after = lattice[site];
      end
      r.mag_total    = MAG_W'(mag_sum);
      r.energy_total = EN_W'(energy_sum);
      return r;
   endfunction

   function automatic plan_row_type beat_row(cmd_type cmd, int site, logic spin_value,
         int value);
      plan_row_type p;
      p.is_csr     = 1'b0;
      p.reg_idx    = CSR_ACCEPT_FOUR;
      p.cmd        = cmd;
      p.site       = SITE_W'(site);
      p.spin_value = spin_value;
      p.value      = RND_W'(value);
      p.typed      = 1'b0;
      p.want       = '0;
      return p;
   endfunction

   function automatic plan_row_type checked_row(cmd_type cmd, int site, logic spin_value,
         int value, logic acc, logic spin_after, int step, int mag, int energy);
      plan_row_type p;
      p = beat_row(cmd, site, spin_value, value);
      p.typed                  = 1'b1;
      p.want.accepted          = acc;
      p.want.spin_after        = spin_after;
      p.want.energy_step       = STEP_W'(step);
      p.want.mag_total         = MAG_W'(mag);
      p.want.energy_total      = EN_W'(energy);
      return p;
   endfunction

   function automatic plan_row_type csr_row(logic [CSR_ADDR_W-1:0] idx, int value);
      plan_row_type p;
      p = beat_row(CMD_NONE, 0, 1'b0, value);
      p.is_csr  = 1'b1;
      p.reg_idx = idx;
      return p;
   endfunction

   task automatic send_beat(input cmd_type cmd, input logic [SITE_W-1:0] site,
         input logic spin_value, input logic [RND_W-1:0] rnd,
         input logic typed = 1'b0, input site_result_type want = '0);
      site_result_type pred;
      @(negedge clock);
      while (!no_gaps && $urandom_range(0, 99) < GAP_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.cmd             <= cmd;
      req_ch.site            <= site;
      req_ch.spin_value      <= spin_value;
      req_ch.random_fraction <= rnd;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      pred = metropolis_update(cmd, site, spin_value, rnd);
      site_results_due.push_back(typed ? want : pred);
      beats_sent++;
      if (cmd == CMD_TRIAL) trials_sent++;
      if (pred.accepted) flips_seen++;
      if (mag_sum == MAG_LIMIT || mag_sum == -MAG_LIMIT ||
          energy_sum == ENERGY_LIMIT || energy_sum == -ENERGY_LIMIT) clamp_hits++;
   endtask

   // registers change only with the unit drained
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
         input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (site_results_due.size() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.addr  <= idx;
      csr_ch.wdata <= data;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) @(posedge clock);
      case (idx)
         CSR_ACCEPT_FOUR:  thr_four  = data;
         CSR_ACCEPT_EIGHT: thr_eight = data;
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // result side: random stalls plus one long hold-off to back the unit up
   initial begin : result_sink
      site_result_type got;
      site_result_type want;
      int hold_left;
      bit hold_done;
      rsp_ch.ready = 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && results_seen >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= no_gaps || $urandom_range(0, 99) >= GAP_PCT;
         end
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got = '{rsp_ch.accepted, rsp_ch.spin_after, rsp_ch.energy_step,
                    rsp_ch.mag_total, rsp_ch.energy_total};
            results_seen++;
            if (site_results_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: result beat with no request outstanding", $realtime);
            end else begin
               want = site_results_due.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX) begin
                     $display("%0t: result %0d: got acc=%0b spin=%0b step=%0d mag=%0d energy=%0d",
                              $realtime, results_seen,
                              got.accepted, got.spin_after, $signed(got.energy_step),
                              $signed(got.mag_total), $signed(got.energy_total));
                     $display("   expected acc=%0b spin=%0b step=%0d mag=%0d energy=%0d",
                              want.accepted, want.spin_after, $signed(want.energy_step),
                              $signed(want.mag_total), $signed(want.energy_total));
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)) begin
         stall_count = 0;
      end else begin
         stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("Watchdog: no beat accepted for %0d cycles", stall_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int phase;
      int pick;
      int row;
      cmd_type cmd;
      logic [SITE_W-1:0] site;
      logic [RND_W-1:0] rnd;
      logic [PROB_W-1:0] four_set[PHASES];
      logic [PROB_W-1:0] eight_set[PHASES];

      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.cmd             = CMD_LOAD;
      req_ch.site            = '0;
      req_ch.spin_value      = 1'b0;
      req_ch.random_fraction = '0;
      csr_ch.valid           = 1'b0;
      csr_ch.addr            = CSR_ACCEPT_FOUR;
      csr_ch.wdata           = '0;
      lattice    = '1;
      mag_sum    = 0;
      energy_sum = 0;
      thr_four   = '0;
      thr_eight  = '0;

      // directed: corners and wrap-around, every command, each threshold edge
      plan.push_back(checked_row(CMD_TRIAL, 0, 1'b0, 16'h0000, 1'b0, 1'b1, 0, 0, 0));
      plan.push_back(checked_row(CMD_LOAD, SITES - 1, 1'b0, 16'h0000, 1'b0, 1'b0, 0, 0, 0));
      plan.push_back(checked_row(CMD_TRIAL, SITES - 1, 1'b0, 16'h0000, 1'b1, 1'b1, -8, 2, -8));
      plan.push_back(checked_row(CMD_NONE, SITES - 1, 1'b1, 16'hFFFF, 1'b0, 1'b1, 0, 2, -8));
      plan.push_back(checked_row(CMD_CLEAR, SITES - 1, 1'b0, 16'h0000, 1'b0, 1'b1, 0, 0, 0));
      plan.push_back(beat_row(CMD_LOAD, 1, 1'b0, 16'h0000));
      plan.push_back(checked_row(CMD_TRIAL, 0, 1'b0, 16'h0000, 1'b0, 1'b1, 0, 0, 0));
      plan.push_back(csr_row(CSR_ACCEPT_FOUR, 16'hFFFF));
      plan.push_back(checked_row(CMD_TRIAL, 0, 1'b0, 16'hFFFF, 1'b0, 1'b1, 0, 0, 0));
      plan.push_back(checked_row(CMD_TRIAL, 0, 1'b0, 16'hFFFE, 1'b1, 1'b0, 4, -2, 4));
      plan.push_back(checked_row(CMD_TRIAL, 0, 1'b0, 16'h0000, 1'b1, 1'b1, -4, 0, 0));
      plan.push_back(beat_row(CMD_LOAD, SIDE, 1'b0, 16'h0000));
      plan.push_back(checked_row(CMD_TRIAL, 0, 1'b0, 16'hFFFF, 1'b1, 1'b0, 0, -2, 0));
      plan.push_back(checked_row(CMD_TRIAL, 0, 1'b0, 16'hFFFF, 1'b1, 1'b1, 0, 0, 0));
      plan.push_back(csr_row(CSR_ACCEPT_FOUR, 16'h0000));
      plan.push_back(csr_row(CSR_ACCEPT_EIGHT, 16'hFFFF));
      plan.push_back(checked_row(CMD_TRIAL, SAT_SITE, 1'b0, 16'hFFFF, 1'b0, 1'b1, 0, 0, 0));
      plan.push_back(checked_row(CMD_TRIAL, SAT_SITE, 1'b0, 16'h0000, 1'b1, 1'b0, 8, -2, 8));
      plan.push_back(checked_row(CMD_TRIAL, SAT_SITE, 1'b0, 16'hFFFF, 1'b1, 1'b1, -8, 0, 0));
      plan.push_back(beat_row(CMD_TRIAL, SIDE - 1, 1'b0, 16'h1234));
      plan.push_back(beat_row(CMD_TRIAL, SITES / 2 - 1, 1'b1, 16'h5A5A));
      plan.push_back(beat_row(CMD_LOAD, SITES / 2, 1'b1, 16'hFFFF));
      plan.push_back(beat_row(CMD_CLEAR, 0, 1'b1, 16'hFFFF));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr)
            write_reg(plan[i].reg_idx, plan[i].value);
         else
            send_beat(plan[i].cmd, plan[i].site, plan[i].spin_value, plan[i].value,
                      plan[i].typed, plan[i].want);
      end

      // random phases, one threshold pair each
      four_set  = '{16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 16'h0001, 16'h0000};
      eight_set = '{16'hFFFF, 16'h0000, 16'h0000, 16'h2000, 16'hFFFE, 16'h0000};
      four_set[2]  = PROB_W'($urandom);
      eight_set[2] = PROB_W'($urandom);
      four_set[5]  = PROB_W'($urandom);
      eight_set[5] = PROB_W'($urandom);
      for (phase = 0; phase < PHASES; phase++) begin
         write_reg(CSR_ACCEPT_FOUR, four_set[phase]);
         write_reg(CSR_ACCEPT_EIGHT, eight_set[phase]);
         repeat (RANDOM_ITEMS / PHASES) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) cmd = CMD_TRIAL;
            else if (pick < 90) cmd = CMD_LOAD;
            else if (pick < 94) cmd = CMD_CLEAR;
            else cmd = CMD_NONE;
            if ($urandom_range(0, 4) == 0) begin
               site = SITE_W'($urandom_range(0, SITES - 1));
            end else begin
               // dense band on the first and last rows keeps neighbors mixed and wraps often
               row = $urandom_range(0, 4);
               if (row > 2) row = SIDE - 5 + row;
               site = SITE_W'(row * SIDE + $urandom_range(0, SIDE - 1));
            end
            case ($urandom_range(0, 9))
               0: rnd = '0;
               1: rnd = '1;
               2: rnd = thr_four - RND_W'($urandom_range(0, 1));
               3: rnd = thr_eight - RND_W'($urandom_range(0, 1));
               default: rnd = RND_W'($urandom);
            endcase
            send_beat(cmd, site, 1'($urandom), rnd);
         end
      end

      // push both totals one way: each load/trial pair moves them one step
      write_reg(CSR_ACCEPT_FOUR, PROB_W'($urandom));
      no_gaps = 1'b1;
      send_beat(CMD_LOAD, SITE_W'(SAT_SITE - SIDE), 1'b1, RND_W'($urandom));
      send_beat(CMD_LOAD, SITE_W'(SAT_SITE + SIDE), 1'b1, RND_W'($urandom));
      send_beat(CMD_LOAD, SITE_W'(SAT_SITE - 1), 1'b1, RND_W'($urandom));
      send_beat(CMD_LOAD, SITE_W'(SAT_SITE + 1), 1'b1, RND_W'($urandom));
      send_beat(CMD_CLEAR, SITE_W'(SAT_SITE), 1'b0, RND_W'($urandom));
      repeat (SAT_PAIRS) begin
         send_beat(CMD_LOAD, SITE_W'(SAT_SITE), 1'b0, RND_W'($urandom));
         send_beat(CMD_TRIAL, SITE_W'(SAT_SITE), 1'($urandom), RND_W'($urandom));
      end
      no_gaps = 1'b0;
      write_reg(CSR_ACCEPT_EIGHT, 16'hFFFF);
      send_beat(CMD_CLEAR, SITE_W'(SAT_SITE), 1'b1, RND_W'($urandom));
      repeat (SAT_PAIRS) begin
         send_beat(CMD_LOAD, SITE_W'(SAT_SITE), 1'b1, RND_W'($urandom));
         send_beat(CMD_TRIAL, SITE_W'(SAT_SITE), 1'($urandom), RND_W'($urandom));
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (site_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d request beats (%0d trials, %0d flips) over %0d register writes,",
               beats_sent, trials_sent, flips_seen, reg_writes);
      $display("with a total at its clamp on %0d beats; %0d mismatches.",
               clamp_hits, mismatch_count);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
